// ===== src/sarw_pkg.sv =====
// ----------------------------------------------------------------------------
// sarw_pkg: shared types and constants of the selective ack receiver window
// Holds field widths, stream packing widths, sequencer states and the status
// word of the shared compare unit.
// ----------------------------------------------------------------------------
package sarw_pkg;

    // Field widths of one packet header and one reply.
    localparam int SEQ_W  = 16;
    localparam int CFG_W  = 13;
    localparam int ACK_W  = 13;
    localparam int SACK_W = 12;

    // Stream packing widths, rounded up to whole bytes.
    localparam int IN_TDATA_W  = 24;
    localparam int OUT_TDATA_W = 32;

    // Reset value of the packet count register.
    localparam logic [CFG_W-1:0] TOTAL_RESET = 13'h1000;

    // Sequencer states.
    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_RANGE,
        ST_CMP,
        ST_WALK_TEST,
        ST_WALK_CHK,
        ST_EMIT
    } sarw_state_t;

    // Status of the shared compare unit.
    typedef struct packed {
        logic lt;
        logic eq;
    } sarw_cmp_t;

endpackage

// ===== src/selective_ack_receiver_window_unit.sv =====
// ----------------------------------------------------------------------------
// selective_ack_receiver_window_unit: selective-repeat receiver window
// Flow: a header passes the range and compare states; the emit state then
//   loads the reply into the output register once that register is free. An
//   in-order packet first takes a bound test and a bitmap read per cached
//   packet the expected number walks over, then a final bound test, and the
//   bitmap read when that test passes. One header is taken at a time; a drop
//   ends in idle, or in the range state when its number is out of range.
// Reset: control state clears at once, then a clearing pass zeroes the
//   bitmap while no header is taken; configuration writes go on.
// ----------------------------------------------------------------------------
module selective_ack_receiver_window_unit #(
    parameter int MAX_PACKETS = 4096
) (
    input  logic                             clk,
    input  logic                             rst_n,
    // Configuration write channel: total_packets.
    input  logic                             cfg_valid,
    output logic                             cfg_ready,
    input  logic [sarw_pkg::CFG_W-1:0]       cfg_data,
    // Header input stream.
    input  logic                             s_tvalid,
    output logic                             s_tready,
    // s_tdata from bit 0: seq_num[15:0], checksum_ok, fin_flag, ack_flag, zero pad
    input  logic [sarw_pkg::IN_TDATA_W-1:0]  s_tdata,
    // Reply output stream.
    output logic                             m_tvalid,
    input  logic                             m_tready,
    // m_tdata from bit 0: cumulative_ack, ack_number[12:0], selective_ack,
    // sack_number[11:0], zero pad
    output logic [sarw_pkg::OUT_TDATA_W-1:0] m_tdata
);
    import sarw_pkg::*;

    localparam int IDX_W = (MAX_PACKETS > 1) ? $clog2(MAX_PACKETS) : 1;
    localparam int EXP_W = $clog2(MAX_PACKETS + 1);
    localparam int CW    = (EXP_W > SEQ_W) ? EXP_W : SEQ_W;

    sarw_state_t       state_reg, state_next;
    logic [CFG_W-1:0]  total_reg;
    logic [EXP_W-1:0]  exp_reg, exp_next;
    logic              closed_reg, closed_next;
    logic [IDX_W-1:0]  clr_cnt_reg, clr_cnt_next;
    logic [SEQ_W-1:0]  seq_reg, seq_next;
    logic              sel_reg, sel_next;
    logic              out_valid_reg, out_valid_next;
    logic [OUT_TDATA_W-1:0] out_data_reg, out_data_next;

    logic [CW-1:0]     lim;
    logic [CW-1:0]     tot_ext;
    logic [CW-1:0]     max_ext;
    logic [CW-1:0]     op_a, op_b, alu_inc;
    sarw_cmp_t         alu_st;
    logic [CW-1:0]     ack_full;

    logic              mem_wr_en, mem_wr_data, mem_rd_en, mem_rd_data;
    logic [IDX_W-1:0]  mem_wr_addr, mem_rd_addr;

    logic              in_fire;

    // The configuration register is always writable.
    assign cfg_ready = 1'b1;
    assign s_tready  = (state_reg == ST_IDLE);
    assign in_fire   = s_tvalid && s_tready;
    assign m_tvalid  = out_valid_reg;
    assign m_tdata   = out_data_reg;

    // Effective packet limit.
    assign tot_ext = CW'(total_reg);
    assign max_ext = CW'(MAX_PACKETS);
    assign lim     = (tot_ext < max_ext) ? tot_ext : max_ext;

    // Cumulative ack value, expected minus one.
    assign ack_full = CW'(exp_reg) - CW'(1);

    // Shared compare unit operand selection.
    always_comb
    begin
        case (state_reg)
            ST_RANGE:
            begin
                op_a = CW'(seq_reg);
                op_b = lim;
            end
            ST_CMP:
            begin
                op_a = CW'(seq_reg);
                op_b = CW'(exp_reg);
            end
            default:
            begin
                op_a = CW'(exp_reg);
                op_b = lim;
            end
        endcase
    end

    sarw_cmp_unit #(
        .W (CW)
    ) u_cmp (
        .op_a   (op_a),
        .op_b   (op_b),
        .status (alu_st),
        .inc    (alu_inc)
    );

    sarw_bitmap #(
        .DEPTH (MAX_PACKETS),
        .IDX_W (IDX_W)
    ) u_bitmap (
        .clk     (clk),
        .wr_en   (mem_wr_en),
        .wr_addr (mem_wr_addr),
        .wr_data (mem_wr_data),
        .rd_en   (mem_rd_en),
        .rd_addr (mem_rd_addr),
        .rd_data (mem_rd_data)
    );

    // Configuration register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            total_reg <= TOTAL_RESET;
        end
        else if (cfg_valid && cfg_ready)
        begin
            total_reg <= cfg_data;
        end
    end

    // Control state registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_CLEAR;
            exp_reg       <= '0;
            closed_reg    <= 1'b0;
            clr_cnt_reg   <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            exp_reg       <= exp_next;
            closed_reg    <= closed_next;
            clr_cnt_reg   <= clr_cnt_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Payload registers.
    always_ff @(posedge clk)
    begin
        seq_reg      <= seq_next;
        sel_reg      <= sel_next;
        out_data_reg <= out_data_next;
    end

    // Sequencer: next state, bitmap access and reply formation.
    always_comb
    begin
        state_next     = state_reg;
        exp_next       = exp_reg;
        closed_next    = closed_reg;
        clr_cnt_next   = clr_cnt_reg;
        seq_next       = seq_reg;
        sel_next       = sel_reg;
        out_valid_next = out_valid_reg;
        out_data_next  = out_data_reg;
        mem_wr_en      = 1'b0;
        mem_wr_addr    = seq_reg[IDX_W-1:0];
        mem_wr_data    = 1'b1;
        mem_rd_en      = 1'b0;
        mem_rd_addr    = exp_reg[IDX_W-1:0];

        // The reply register empties on its transaction.
        if (out_valid_reg && m_tready)
        begin
            out_valid_next = 1'b0;
        end

        case (state_reg)
            ST_CLEAR:
            begin
                mem_wr_en    = 1'b1;
                mem_wr_addr  = clr_cnt_reg;
                mem_wr_data  = 1'b0;
                clr_cnt_next = clr_cnt_reg + IDX_W'(1);
                if (clr_cnt_reg == IDX_W'(MAX_PACKETS - 1))
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE:
            begin
                if (in_fire)
                begin
                    seq_next = s_tdata[SEQ_W-1:0];
                    if (closed_reg || !s_tdata[SEQ_W])
                    begin
                        // Closed window or bad checksum: dropped.
                        state_next = ST_IDLE;
                    end
                    else if (s_tdata[SEQ_W+1] && s_tdata[SEQ_W+2])
                    begin
                        // Fin with ack closes the window.
                        closed_next = 1'b1;
                    end
                    else
                    begin
                        state_next = ST_RANGE;
                    end
                end
            end
            ST_RANGE:
            begin
                // Sequence numbers beyond the transfer are dropped.
                state_next = alu_st.lt ? ST_CMP : ST_IDLE;
            end
            ST_CMP:
            begin
                if (alu_st.eq)
                begin
                    exp_next   = alu_inc[EXP_W-1:0];
                    state_next = ST_WALK_TEST;
                end
                else if (alu_st.lt)
                begin
                    // Duplicate: repeat the cumulative ack.
                    sel_next   = 1'b0;
                    state_next = ST_EMIT;
                end
                else
                begin
                    // Out of order: cache it and ack it selectively.
                    mem_wr_en  = 1'b1;
                    sel_next   = 1'b1;
                    state_next = ST_EMIT;
                end
            end
            ST_WALK_TEST:
            begin
                // Bound test comes before the bitmap read.
                sel_next = 1'b0;
                if (alu_st.lt)
                begin
                    mem_rd_en  = 1'b1;
                    state_next = ST_WALK_CHK;
                end
                else
                begin
                    state_next = ST_EMIT;
                end
            end
            ST_WALK_CHK:
            begin
                if (mem_rd_data)
                begin
                    exp_next   = alu_inc[EXP_W-1:0];
                    state_next = ST_WALK_TEST;
                end
                else
                begin
                    state_next = ST_EMIT;
                end
            end
            ST_EMIT:
            begin
                if (!out_valid_reg || m_tready)
                begin
                    out_valid_next = 1'b1;
                    out_data_next  = '0;
                    if (sel_reg)
                    begin
                        out_data_next[ACK_W+1]                 = 1'b1;
                        out_data_next[ACK_W+SACK_W+1:ACK_W+2]  = seq_reg[SACK_W-1:0];
                    end
                    else
                    begin
                        out_data_next[0]       = 1'b1;
                        out_data_next[ACK_W:1] = ack_full[ACK_W-1:0];
                    end
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

endmodule

// ===== src/sarw_cmp_unit.sv =====
// ----------------------------------------------------------------------------
// sarw_cmp_unit: shared compare and increment unit
// One magnitude compare and one incrementer, reused by the sequencer for the
// range test, the window test and every step of the advance walk.
// ----------------------------------------------------------------------------
module sarw_cmp_unit #(
    parameter int W = 16
) (
    input  logic [W-1:0]        op_a,
    input  logic [W-1:0]        op_b,
    output sarw_pkg::sarw_cmp_t status,
    output logic [W-1:0]        inc
);
    import sarw_pkg::*;

    // Compare operand A against operand B.
    always_comb
    begin
        status.lt = (op_a < op_b);
        status.eq = (op_a == op_b);
    end

    // Operand A plus one.
    assign inc = op_a + W'(1);

endmodule

// ===== src/sarw_bitmap.sv =====
// ----------------------------------------------------------------------------
// sarw_bitmap: cached-packet bitmap memory
// One bit per sequence number, one write port and one registered read port.
// ----------------------------------------------------------------------------
module sarw_bitmap #(
    parameter int DEPTH = 4096,
    parameter int IDX_W = 12
) (
    input  logic             clk,
    input  logic             wr_en,
    input  logic [IDX_W-1:0] wr_addr,
    input  logic             wr_data,
    input  logic             rd_en,
    input  logic [IDX_W-1:0] rd_addr,
    output logic             rd_data
);
    import sarw_pkg::*;

    logic mem [DEPTH];
    logic rd_data_reg;

    // Write port.
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

    // Registered read port.
    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

// ===== src/sarw_checker.sv =====
// ----------------------------------------------------------------------------
// sarw_checker: port-level assertions for the receiver window
// Watches the header and reply streams and checks the reply encoding over time.
// ----------------------------------------------------------------------------
module sarw_checker (
    input logic                             clk,
    input logic                             rst_n,
    input logic                             s_tvalid,
    input logic                             s_tready,
    input logic                             m_tvalid,
    input logic                             m_tready,
    input logic [sarw_pkg::OUT_TDATA_W-1:0] m_tdata
);
    import sarw_pkg::*;

    // A stalled header stays offered.
    a_hold_hdr: assert property (@(posedge clk) disable iff (!rst_n)
        s_tvalid && !s_tready |=> s_tvalid)
        else $error("header withdrawn while stalled");

    // A stalled reply stays offered.
    a_hold_valid: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid)
        else $error("reply dropped while stalled");

    // Every reply is exactly one kind of ack.
    a_one_kind: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> (m_tdata[0] ^ m_tdata[ACK_W+1]))
        else $error("reply is not exactly one ack kind");

    // A selective ack carries a zero ack number.
    a_sel_zero: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && m_tdata[ACK_W+1] |-> (m_tdata[ACK_W:1] == '0))
        else $error("selective ack with nonzero ack number");

    // A cumulative ack carries a zero sack number.
    a_cum_zero: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && m_tdata[0] |-> (m_tdata[ACK_W+SACK_W+1:ACK_W+2] == '0))
        else $error("cumulative ack with nonzero sack number");

endmodule

bind selective_ack_receiver_window_unit sarw_checker u_sarw_checker (
    .clk      (clk),
    .rst_n    (rst_n),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
);
